### design/hed_pkg.sv
// hed_pkg: shared types, character codes and the entity name table
// for the html entity decoder; no dependencies
package hed_pkg;

	localparam int N_NAMES  = 5;
	localparam int NAME_LEN = 5;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CODE_LIMIT = 8'd128;
	localparam logic [7:0] CODE_SAT   = 8'd255;

	typedef logic [2:0] name_idx_t;

	// match phase of the front end
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_AMP     = 4'b0010,
		PH_NAMED   = 4'b0100,
		PH_NUMERIC = 4'b1000
	} phase_t;

	// result slot of the back end sequencer
	typedef enum logic [5:0] {
		SL_AMP   = 6'b000001,
		SL_HELD  = 6'b000010,
		SL_TAIL  = 6'b000100,
		SL_TRAIL = 6'b001000,
		SL_EMPTY = 6'b010000,
		SL_DONE  = 6'b100000
	} slot_t;

	// one request from front to back: optional flush of held bytes,
	// optional tail byte, optional trailing '&', end of text flag
	typedef struct packed {
		logic       flush;
		logic       tail_vld;
		logic [7:0] tail_char;
		logic       trail_amp;
		logic       eot;
	} cmd_t;

	localparam logic [7:0] NAME_TAB [N_NAMES][NAME_LEN] = '{
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
		'{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
	};

	localparam logic [7:0] NAME_VAL [N_NAMES] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h20};

	function automatic logic [7:0] name_char(input name_idx_t k, input logic [2:0] pos);
		logic [7:0] r;
		r = 8'h00;
		if (int'(k) < N_NAMES && int'(pos) < NAME_LEN) begin
			r = NAME_TAB[k][pos];
		end
		return r;
	endfunction

	function automatic logic [7:0] name_value(input name_idx_t k);
		logic [7:0] r;
		r = 8'h00;
		if (int'(k) < N_NAMES) begin
			r = NAME_VAL[k];
		end
		return r;
	endfunction

endpackage

### design/hed_in_if.sv
// hed_in_if: input byte channel of the html entity decoder
// valid/ready handshake with the text byte payload; no dependencies
interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_text;

	modport source(output valid, in_char, end_of_text, input ready);
	modport sink(input valid, in_char, end_of_text, output ready);
endinterface

### design/hed_out_if.sv
// hed_out_if: result channel of the html entity decoder
// valid/ready handshake with the decoded byte payload; no dependencies
interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       has_char;
	logic       last_of_run;
	logic       text_done;

	modport source(output valid, out_char, has_char, last_of_run, text_done, input ready);
	modport sink(input valid, out_char, has_char, last_of_run, text_done, output ready);
endinterface

### design/hed_front.sv
// hed_front: accepts text bytes, tracks the entity match and issues
// one request per byte that causes results; uses hed_pkg, hed_in_if
module hed_front #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hed_in_if.sink                text_in,
	output logic                  push,
	output hed_pkg::cmd_t         cmd,
	output logic [$clog2(MAX_DIGITS+2)-1:0] snap_cnt,
	output logic [(MAX_DIGITS+1)*8-1:0]     snap_held,
	input  logic                  q_ready
);
	localparam int HELD  = MAX_DIGITS + 1;
	localparam int CNT_W = $clog2(HELD + 1);
	localparam int IDX_W = $clog2(HELD);

	hed_pkg::phase_t    phase_q, phase_n;
	hed_pkg::name_idx_t name_q, name_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n, cnt_w;
	logic [7:0]         acc_q, acc_n;
	logic [7:0]         held_q [HELD];
	logic [7:0]         held_w [HELD];

	logic       acc_en;
	logic [7:0] c;
	logic       eot, fail, do_hold, do_idle, emit_v, end_flush, trail, found, is_digit;
	logic [7:0] emit_c;
	logic [11:0] acc_sum;
	hed_pkg::name_idx_t k_hit;

	assign c        = text_in.in_char;
	assign eot      = text_in.end_of_text;
	assign acc_en   = text_in.valid && text_in.ready;
	assign text_in.ready = q_ready;
	assign is_digit = (c >= hed_pkg::CH_ZERO) && (c <= hed_pkg::CH_NINE);
	assign acc_sum  = 12'(acc_q) * 12'd10 + 12'(c - hed_pkg::CH_ZERO);

	always_comb begin
		found = 1'b0;
		k_hit = '0;
		for (int k = 0; k < hed_pkg::N_NAMES; k++) begin
			if (!found && hed_pkg::name_char(3'(k), 3'd0) == c) begin
				found = 1'b1;
				k_hit = 3'(k);
			end
		end
	end

	always_comb begin
		phase_n = phase_q;
		name_n  = name_q;
		acc_n   = acc_q;
		fail    = 1'b0;
		do_hold = 1'b0;
		do_idle = 1'b0;
		emit_v  = 1'b0;
		emit_c  = c;
		unique case (phase_q)
			hed_pkg::PH_IDLE: begin
				if (c == hed_pkg::CH_AMP) begin
					phase_n = hed_pkg::PH_AMP;
				end else begin
					emit_v = 1'b1;
				end
			end
			hed_pkg::PH_AMP: begin
				if (c == hed_pkg::CH_HASH) begin
					do_hold = 1'b1;
					acc_n   = '0;
					phase_n = hed_pkg::PH_NUMERIC;
				end else if (found) begin
					do_hold = 1'b1;
					name_n  = k_hit;
					phase_n = hed_pkg::PH_NAMED;
				end else begin
					fail = 1'b1;
				end
			end
			hed_pkg::PH_NUMERIC: begin
				if (is_digit) begin
					if (cnt_q >= CNT_W'(HELD)) begin
						fail = 1'b1;
					end else begin
						do_hold = 1'b1;
						acc_n   = (acc_sum > 12'(hed_pkg::CODE_SAT)) ? hed_pkg::CODE_SAT
						                                             : acc_sum[7:0];
					end
				end else if (c == hed_pkg::CH_SEMI) begin
					emit_v  = (acc_q != '0) && (acc_q < hed_pkg::CODE_LIMIT);
					emit_c  = acc_q;
					do_idle = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end
			hed_pkg::PH_NAMED: begin
				if (cnt_q < CNT_W'(hed_pkg::NAME_LEN) &&
				    hed_pkg::name_char(name_q, 3'(cnt_q)) == c) begin
					if (c == hed_pkg::CH_SEMI) begin
						emit_v  = 1'b1;
						emit_c  = hed_pkg::name_value(name_q);
						do_idle = 1'b1;
					end else begin
						do_hold = 1'b1;
					end
				end else begin
					fail = 1'b1;
				end
			end
			default: begin
				// unknown phase: restart as if idle
				phase_n = hed_pkg::PH_IDLE;
				do_idle = 1'b1;
				emit_v  = (c != hed_pkg::CH_AMP);
			end
		endcase
		if (do_idle) begin
			phase_n = hed_pkg::PH_IDLE;
			acc_n   = '0;
		end
		// failed match: flush, then the byte is taken afresh from idle
		if (fail) begin
			acc_n   = '0;
			phase_n = (c == hed_pkg::CH_AMP) ? hed_pkg::PH_AMP : hed_pkg::PH_IDLE;
			emit_v  = (c != hed_pkg::CH_AMP);
			emit_c  = c;
		end
	end

	// held bytes after this byte is stored
	always_comb begin
		for (int i = 0; i < HELD; i++) begin
			held_w[i] = held_q[i];
		end
		cnt_w = cnt_q;
		if (do_hold && cnt_q < CNT_W'(HELD)) begin
			held_w[cnt_q[IDX_W-1:0]] = c;
			cnt_w = cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		for (int i = 0; i < HELD; i++) begin
			snap_held[i*8 +: 8] = held_w[i];
		end
	end

	assign end_flush = !fail && eot && (phase_n != hed_pkg::PH_IDLE);
	assign trail     = fail && eot && (c == hed_pkg::CH_AMP);
	assign cnt_n     = (fail || do_idle || eot) ? '0 : cnt_w;
	assign snap_cnt  = cnt_w;

	assign cmd.flush     = fail || end_flush;
	assign cmd.tail_vld  = emit_v;
	assign cmd.tail_char = emit_c;
	assign cmd.trail_amp = trail;
	assign cmd.eot       = eot;
	assign push = acc_en && (fail || end_flush || emit_v || eot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hed_pkg::PH_IDLE;
			name_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
		end else if (acc_en) begin
			phase_q <= eot ? hed_pkg::PH_IDLE : phase_n;
			name_q  <= name_n;
			cnt_q   <= cnt_n;
			acc_q   <= eot ? '0 : acc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			for (int i = 0; i < HELD; i++) begin
				held_q[i] <= held_w[i];
			end
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hed_pkg::PH_IDLE || phase_q == hed_pkg::PH_AMP |-> cnt_q == '0)
		else $error("idle or amp phase with held bytes");

	a_named_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hed_pkg::PH_NAMED |-> cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(4))
		else $error("named match with bad held count");

endmodule

### design/hed_queue.sv
// hed_queue: small request fifo between front and back
// of the html entity decoder; no dependencies
module hed_queue #(
	parameter int W     = 16,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         pop_valid
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q < CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("request pushed into full queue");

endmodule

### design/hed_back.sv
// hed_back: steps through each request and delivers its result bytes
// through an output register; uses hed_pkg, hed_out_if
module hed_back #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  hed_pkg::cmd_t         q_cmd,
	input  logic [$clog2(MAX_DIGITS+2)-1:0] q_cnt,
	input  logic [(MAX_DIGITS+1)*8-1:0]     q_held,
	output logic                  q_pop,
	hed_out_if.source             text_out
);
	localparam int HELD  = MAX_DIGITS + 1;
	localparam int CNT_W = $clog2(HELD + 1);
	localparam int IDX_W = $clog2(HELD);

	logic             busy_q;
	hed_pkg::slot_t   slot_q, slot_nxt, slot_first, slot_later;
	hed_pkg::cmd_t    cmd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       hb_q [HELD];

	logic       out_free, adv, last;
	logic [7:0] res_char;
	logic       res_has;

	logic       ov_q;
	logic [7:0] och_q;
	logic       ohas_q, olast_q, odone_q;

	assign out_free = !ov_q || text_out.ready;
	assign adv      = busy_q && out_free;
	assign last     = slot_nxt == hed_pkg::SL_DONE;
	assign q_pop    = q_valid && (!busy_q || (adv && last));

	always_comb begin
		if (q_cmd.flush) begin
			slot_first = hed_pkg::SL_AMP;
		end else if (q_cmd.tail_vld) begin
			slot_first = hed_pkg::SL_TAIL;
		end else if (q_cmd.trail_amp) begin
			slot_first = hed_pkg::SL_TRAIL;
		end else begin
			slot_first = hed_pkg::SL_EMPTY;
		end
	end

	always_comb begin
		slot_later = cmd_q.tail_vld ? hed_pkg::SL_TAIL :
		             (cmd_q.trail_amp ? hed_pkg::SL_TRAIL : hed_pkg::SL_DONE);
		unique case (slot_q)
			hed_pkg::SL_AMP:   slot_nxt = (cnt_q != '0) ? hed_pkg::SL_HELD : slot_later;
			hed_pkg::SL_HELD:  slot_nxt = (CNT_W'(idx_q) + CNT_W'(1) < cnt_q) ? hed_pkg::SL_HELD
			                                                               : slot_later;
			hed_pkg::SL_TAIL:  slot_nxt = cmd_q.trail_amp ? hed_pkg::SL_TRAIL : hed_pkg::SL_DONE;
			default:           slot_nxt = hed_pkg::SL_DONE;
		endcase
	end

	always_comb begin
		unique case (slot_q)
			hed_pkg::SL_AMP: begin
				res_char = hed_pkg::CH_AMP;
				res_has  = 1'b1;
			end
			hed_pkg::SL_HELD: begin
				res_char = hb_q[idx_q];
				res_has  = 1'b1;
			end
			hed_pkg::SL_TAIL: begin
				res_char = cmd_q.tail_char;
				res_has  = 1'b1;
			end
			hed_pkg::SL_TRAIL: begin
				res_char = hed_pkg::CH_AMP;
				res_has  = 1'b1;
			end
			default: begin
				res_char = 8'h00;
				res_has  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= hed_pkg::SL_DONE;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				slot_q <= slot_first;
				idx_q  <= '0;
			end else if (adv && last) begin
				busy_q <= 1'b0;
				slot_q <= hed_pkg::SL_DONE;
			end else if (adv) begin
				if (slot_q == hed_pkg::SL_HELD) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				slot_q <= slot_nxt;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (text_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			cnt_q <= q_cnt;
			for (int i = 0; i < HELD; i++) begin
				hb_q[i] <= q_held[i*8 +: 8];
			end
		end
		if (adv) begin
			och_q   <= res_char;
			ohas_q  <= res_has;
			olast_q <= last;
			odone_q <= last && cmd_q.eot;
		end
	end

	assign text_out.valid       = ov_q;
	assign text_out.out_char    = och_q;
	assign text_out.has_char    = ohas_q;
	assign text_out.last_of_run = olast_q;
	assign text_out.text_done   = odone_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && odone_q |-> olast_q)
		else $error("text done on a result that is not last of run");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !ohas_q |-> odone_q && och_q == 8'h00)
		else $error("empty marker outside end of text");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && slot_q == hed_pkg::SL_HELD |-> CNT_W'(idx_q) < cnt_q)
		else $error("held byte index beyond held count");

endmodule

### design/html_entity_decoder.sv
// html_entity_decoder: streaming entity decoder, one text byte per request.
// a byte's first result passes the queue and sequencer registers to the
// output register; plain text runs at one byte per cycle while the output
// is ready, and a byte with n results (at most MAX_DIGITS+3) holds the
// sequencer until all are out, a two-entry queue absorbing the difference.
// reset: arst_n clears match phase, counts, queue and output valid at once.
module html_entity_decoder #(
	parameter int MAX_DIGITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	hed_in_if.sink    text_in,
	hed_out_if.source text_out
);
	// held bytes are '#' plus the longest digit run
	localparam int HELD    = MAX_DIGITS + 1;
	localparam int CNT_W   = $clog2(HELD + 1);
	localparam int Q_DEPTH = 2;
	localparam int Q_W     = $bits(hed_pkg::cmd_t) + CNT_W + HELD * 8;

	// front side request
	logic               push;
	hed_pkg::cmd_t      f_cmd;
	logic [CNT_W-1:0]   f_cnt;
	logic [HELD*8-1:0]  f_held;
	logic               q_ready;

	// back side request
	logic               q_valid, q_pop;
	logic [Q_W-1:0]     q_data;
	hed_pkg::cmd_t      b_cmd;
	logic [CNT_W-1:0]   b_cnt;
	logic [HELD*8-1:0]  b_held;

	// front: match tracking, one request per byte that produces results
	hed_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.push      (push),
		.cmd       (f_cmd),
		.snap_cnt  (f_cnt),
		.snap_held (f_held),
		.q_ready   (q_ready)
	);

	// requests carry a snapshot of the held bytes so the front can move on
	hed_queue #(.W(Q_W), .DEPTH(Q_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({f_cmd, f_cnt, f_held}),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_data   (q_data),
		.pop_valid  (q_valid)
	);

	assign {b_cmd, b_cnt, b_held} = q_data;

	// back: result sequencer and output register
	hed_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (b_cmd),
		.q_cnt    (b_cnt),
		.q_held   (b_held),
		.q_pop    (q_pop),
		.text_out (text_out)
	);

endmodule

### tb/testbench.sv
// testbench: self-checking bench for html_entity_decoder, random text with entity fragments
// depends on hed_pkg, hed_in_if, hed_out_if and the decoder rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIGITS  = 8;
	localparam int HELD_DEPTH  = MAX_DIGITS + 1;
	localparam int N_ENTITIES  = 5;
	localparam int RANDOM_BYTES = 156;
	localparam int CALM_TAIL   = 30;   // last requests run with no idling
	localparam int STALL_LIMIT = 2000; // cycles with no handshake at all
	localparam int SQUEEZE_AT  = 60;   // results seen before the long receiver hold
	localparam int SQUEEZE_LEN = 300;
	localparam int DRAIN_WAIT  = 24;

	localparam logic [7:0] AMP   = 8'h26;
	localparam logic [7:0] HASH  = 8'h23;
	localparam logic [7:0] SEMI  = 8'h3B;
	localparam logic [7:0] DIGIT0 = 8'h30;
	localparam logic [7:0] DIGIT9 = 8'h39;
	localparam int CODE_TOP = 255;
	localparam int ASCII_END = 128;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       last;
		logic       done;
	} decoded_t;

	logic clk;
	logic arst_n;

	hed_in_if  text_ch();
	hed_out_if res_ch();

	html_entity_decoder #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_ch),
		.text_out(res_ch)
	);

	// text bytes still to be offered, and decoded bytes still owed by the block
	text_byte_t pending_bytes[$];
	decoded_t   expected_chars[$];
	decoded_t   run_out[$];

	// decoder state kept by the bench
	hed_pkg::phase_t dec_phase;
	int              dec_name;
	logic [7:0]      dec_held[HELD_DEPTH];
	int              dec_held_n;
	int              dec_code;

	int mismatches = 0;
	int results_taken = 0;

	// ------------------------------------------------------------------
	// entity name table: spelling after the '&', and the decoded byte
	// ------------------------------------------------------------------
	function automatic logic [7:0] entity_byte(int k, int pos);
		string s;
		case (k)
			0: s = "lt;";
			1: s = "gt;";
			2: s = "amp;";
			3: s = "quot;";
			default: s = "nbsp;";
		endcase
		return (pos < s.len()) ? s[pos] : 8'h00;
	endfunction

	function automatic logic [7:0] entity_value(int k);
		case (k)
			0: return 8'h3C;
			1: return 8'h3E;
			2: return 8'h26;
			3: return 8'h22;
			default: return 8'h20;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// decoder prediction
	// ------------------------------------------------------------------
	function automatic void put_result(logic [7:0] ch, logic has);
		run_out.push_back(decoded_t'{ch: ch, has: has, last: 1'b0, done: 1'b0});
	endfunction

	function automatic void drop_match();
		dec_phase  = hed_pkg::PH_IDLE;
		dec_held_n = 0;
		dec_code   = 0;
	endfunction

	// failed match: '&' then everything held, literally
	function automatic void flush_held();
		put_result(AMP, 1'b1);
		for (int i = 0; i < dec_held_n && i < HELD_DEPTH; i++) begin
			put_result(dec_held[i], 1'b1);
		end
		drop_match();
	endfunction

	function automatic void hold_byte(logic [7:0] c);
		if (dec_held_n < HELD_DEPTH) begin
			dec_held[dec_held_n] = c;
			dec_held_n++;
		end
	endfunction

	// a byte seen with no entity open
	function automatic void plain_byte(logic [7:0] c);
		if (c == AMP) begin
			drop_match();
			dec_phase = hed_pkg::PH_AMP;
		end else begin
			put_result(c, 1'b1);
		end
	endfunction

	// one accepted request: work out its results and queue them
	function automatic void decode_byte(logic [7:0] c, logic eot);
		int hit;
		run_out.delete();
		case (dec_phase)
			hed_pkg::PH_IDLE: begin
				plain_byte(c);
			end
			hed_pkg::PH_AMP: begin
				if (c == HASH) begin
					hold_byte(c);
					dec_code  = 0;
					dec_phase = hed_pkg::PH_NUMERIC;
				end else begin
					hit = -1;
					for (int k = 0; k < N_ENTITIES; k++) begin
						if (entity_byte(k, 0) == c) begin
							hit = k;
						end
					end
					if (hit >= 0) begin
						hold_byte(c);
						dec_name  = hit;
						dec_phase = hed_pkg::PH_NAMED;
					end else begin
						flush_held();
						plain_byte(c);
					end
				end
			end
			hed_pkg::PH_NUMERIC: begin
				if (c >= DIGIT0 && c <= DIGIT9) begin
					if (dec_held_n >= 1 + MAX_DIGITS) begin
						// one digit too many: give up on the entity
						flush_held();
						plain_byte(c);
					end else begin
						hold_byte(c);
						dec_code = dec_code * 10 + int'(c - DIGIT0);
						if (dec_code > CODE_TOP) begin
							dec_code = CODE_TOP;
						end
					end
				end else if (c == SEMI) begin
					if (dec_code >= 1 && dec_code < ASCII_END) begin
						put_result(dec_code[7:0], 1'b1);
					end
					drop_match();
				end else begin
					flush_held();
					plain_byte(c);
				end
			end
			hed_pkg::PH_NAMED: begin
				if (dec_held_n < 5 && entity_byte(dec_name, dec_held_n) == c) begin
					if (c == SEMI) begin
						put_result(entity_value(dec_name), 1'b1);
						drop_match();
					end else begin
						hold_byte(c);
					end
				end else begin
					flush_held();
					plain_byte(c);
				end
			end
			default: begin
				drop_match();
				plain_byte(c);
			end
		endcase
		if (eot) begin
			if (dec_phase != hed_pkg::PH_IDLE) begin
				flush_held();
			end
			drop_match();
			// end of text with nothing to say still gets a marker
			if (run_out.size() == 0) begin
				put_result(8'h00, 1'b0);
			end
		end
		if (run_out.size() > 0) begin
			run_out[run_out.size() - 1].last = 1'b1;
			run_out[run_out.size() - 1].done = eot;
		end
		foreach (run_out[i]) begin
			expected_chars.push_back(run_out[i]);
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_byte(logic [7:0] c, logic eot);
		pending_bytes.push_back(text_byte_t'{ch: c, eot: eot});
	endfunction

	// random end of text, roughly one byte in 25
	function automatic void add_rand_end(logic [7:0] c);
		add_byte(c, $urandom_range(0, 24) == 0);
	endfunction

	function automatic void add_text(string s, logic eot_last);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i], eot_last && (i == s.len() - 1));
		end
	endfunction

	// idling chance per cycle for the current mode: none, light or heavy
	function automatic bit idle_roll(int mode);
		case (mode)
			1: return $urandom_range(0, 15) == 0;
			2: return $urandom_range(0, 3) == 0;
			default: return 1'b0;
		endcase
	endfunction

	// one fragment of random text: plain bytes, or well-formed or broken entities
	function automatic void add_fragment();
		int kind;
		int k;
		int n;
		int pos;
		kind = $urandom_range(0, 9);
		k = $urandom_range(0, N_ENTITIES - 1);
		case (kind)
			0, 1, 2: begin
				repeat ($urandom_range(1, 3)) add_rand_end(8'($urandom_range(1, 255)));
			end
			3, 4: begin
				// complete named entity
				add_rand_end(AMP);
				pos = 0;
				while (entity_byte(k, pos) != 8'h00) begin
					add_rand_end(entity_byte(k, pos));
					pos++;
				end
			end
			5, 6, 7: begin
				// numeric entity, sometimes overlong, sometimes left open
				add_rand_end(AMP);
				add_rand_end(HASH);
				if ($urandom_range(0, 5) == 0) begin
					n = $urandom_range(MAX_DIGITS, MAX_DIGITS + 2);
				end else begin
					n = $urandom_range(0, 3);
				end
				repeat (n) add_rand_end(DIGIT0 + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 4) != 0) begin
					add_rand_end(SEMI);
				end else begin
					add_rand_end(8'($urandom_range(1, 255)));
				end
			end
			8: begin
				// named entity cut short by a stray byte
				add_rand_end(AMP);
				n = 0;
				while (entity_byte(k, n) != 8'h00) n++;
				n = $urandom_range(1, n - 1);
				for (pos = 0; pos < n; pos++) begin
					add_rand_end(entity_byte(k, pos));
				end
				add_rand_end(8'($urandom_range(1, 255)));
			end
			default: begin
				add_rand_end(AMP);
				add_rand_end(8'($urandom_range(1, 255)));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// text driver: offers pending bytes, holds a request until taken
	// ------------------------------------------------------------------
	int tx_gap;
	int tx_mode;
	int tx_mode_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid       <= 1'b0;
			text_ch.in_char     <= 8'h00;
			text_ch.end_of_text <= 1'b0;
			tx_gap       = 0;
			tx_mode      = 0;
			tx_mode_left = 0;
			drop_match();
			dec_name     = 0;
		end else begin
			// request taken this edge: predict from it and retire it
			if (text_ch.valid && text_ch.ready) begin
				decode_byte(pending_bytes[0].ch, pending_bytes[0].eot);
				void'(pending_bytes.pop_front());
			end
			// idling mode is redrawn when its random span runs out
			if (tx_mode_left == 0) begin
				tx_mode      = $urandom_range(0, 2);
				tx_mode_left = $urandom_range(16, 96);
			end else begin
				tx_mode_left--;
			end
			// a stalled request stays on the bus untouched
			if (!(text_ch.valid && !text_ch.ready)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					text_ch.valid <= 1'b0;
				end else if (pending_bytes.size() > CALM_TAIL && idle_roll(tx_mode)) begin
					tx_gap = $urandom_range(0, 17);
					text_ch.valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					text_ch.valid       <= 1'b1;
					text_ch.in_char     <= pending_bytes[0].ch;
					text_ch.end_of_text <= pending_bytes[0].eot;
				end else begin
					text_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: checks each taken result against the oldest
	// expectation, and throttles ready
	// ------------------------------------------------------------------
	int  rx_gap;
	int  rx_mode;
	int  rx_mode_left;
	int  squeeze_left;
	bit  squeeze_done;

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_gap       = 0;
			rx_mode      = 0;
			rx_mode_left = 0;
			squeeze_left = 0;
			squeeze_done = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_taken++;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h/%b/%b/%b", $time,
						res_ch.out_char, res_ch.has_char, res_ch.last_of_run, res_ch.text_done);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					check_field("out_char", want.ch, res_ch.out_char);
					check_field("has_char", 8'(want.has), 8'(res_ch.has_char));
					check_field("last_of_run", 8'(want.last), 8'(res_ch.last_of_run));
					check_field("text_done", 8'(want.done), 8'(res_ch.text_done));
				end
			end
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(16, 96);
			end else begin
				rx_mode_left--;
			end
			if (squeeze_left > 0) begin
				squeeze_left--;
				res_ch.ready <= 1'b0;
			end else if (!squeeze_done && results_taken >= SQUEEZE_AT) begin
				// one long hold so the block backs up into its input
				squeeze_done = 1'b1;
				squeeze_left = SQUEEZE_LEN - 1;
				res_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				res_ch.ready <= 1'b0;
			end else if (pending_bytes.size() > CALM_TAIL && idle_roll(rx_mode)) begin
				rx_gap = $urandom_range(0, 17);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long with no request and no result moving
	// ------------------------------------------------------------------
	int stall_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int directed_n;

		// directed: one named form, good and large numeric codes,
		// empty code ending the text (empty end marker), partial entity at end,
		// zero byte and byte extremes
		add_text("&lt;", 1'b0);
		add_text("&#65;", 1'b0);
		add_text("&#300;", 1'b0);
		add_text("&#;", 1'b1);
		add_text("&g", 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h01, 1'b1);
		directed_n = pending_bytes.size();

		while (pending_bytes.size() < directed_n + RANDOM_BYTES) begin
			add_fragment();
		end
		// close the text so nothing stays held
		pending_bytes[pending_bytes.size() - 1].eot = 1'b1;

		@(posedge arst_n);
		while (pending_bytes.size() > 0 || text_ch.valid) @(posedge clk);
		while (expected_chars.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

### sim.f
design/hed_pkg.sv
design/hed_in_if.sv
design/hed_out_if.sv
design/hed_front.sv
design/hed_queue.sv
design/hed_back.sv
design/html_entity_decoder.sv
tb/testbench.sv
